/* rtl/box_downsample_2x2_rgba8_macros.svh */
// Assertion macros for the 2x2 box downsampler.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef BOX_DOWNSAMPLE_2X2_RGBA8_MACROS_SVH
`define BOX_DOWNSAMPLE_2X2_RGBA8_MACROS_SVH
`ifndef SYNTHESIS
`define BDS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("box downsampler check failed");
`define BDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("box downsampler check failed");
`else
`define BDS_ASSERT_SAME(label, clk, rst, ante, cons)
`define BDS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/bds_pkg.sv */
// Shared types and constants for the 2x2 box downsampler.
// Used by the top level and the testbench; depends on nothing.
package bds_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 4096;
   localparam int DEFAULT_MAX_HEIGHT = 4096;

   localparam int CFG_DIM_WIDTH = 13;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic {
      REG_SRC_WIDTH  = 1'b0,
      REG_SRC_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [7:0] in_ch0;
      logic [7:0] in_ch1;
      logic [7:0] in_ch2;
      logic [7:0] in_ch3;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] out_ch0;
      logic [7:0] out_ch1;
      logic [7:0] out_ch2;
      logic [7:0] out_ch3;
      logic       last_pixel;
   } pixel_out_type;

   // Four 9-bit horizontal pair sums, lane k for byte k.
   typedef logic [3:0][8:0] quad_sum_type;

   localparam int QUAD_SUM_WIDTH = $bits(quad_sum_type);

endpackage

/* rtl/bds_line_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Holds the line of pair sums; depends on nothing.
module bds_line_ram #(
   parameter int WIDTH      = 36,
   parameter int DEPTH      = 2048,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/box_downsample_2x2_rgba8.sv */
// Top level of the 2x2 box downsampler for RGBA8 mip generation.
// Depends on bds_pkg, bds_line_ram and box_downsample_2x2_rgba8_macros.svh.
//
//   Port group   Direction  Handshake            Carries
//   req_*        in         req_valid/req_ready  one source pixel
//   rsp_*        out        rsp_valid/rsp_ready  one averaged pixel and last flag
//   p*           in/out     APB, pready high     src_width at 0, src_height at 4
//
// One source pixel is taken every cycle while req_ready is high.
// A result passes through the sum stage, beside the registered read of the line RAM, and the result register.
// Reset is synchronous: counters clear and both dimensions return to 1; no clearing pass.
// A stalled result holds the pipeline, and req_ready falls only while both stages are full.
`include "box_downsample_2x2_rgba8_macros.svh"
module box_downsample_2x2_rgba8
   import bds_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pixel_in_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pixel_out_type             rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int RW         = $clog2(MAX_HEIGHT);
   localparam int DWW        = $clog2(MAX_WIDTH + 1);
   localparam int DWH        = $clog2(MAX_HEIGHT + 1);
   localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
   localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic [CFG_DIM_WIDTH-1:0] src_width_ff, src_width_in;
   logic [CFG_DIM_WIDTH-1:0] src_height_ff, src_height_in;
   logic [DWW-1:0]           eff_w_ff, eff_w_in;
   logic [DWH-1:0]           eff_h_ff, eff_h_in;
   logic                     cfg_write;
   int unsigned              wr_value;

   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   quad_sum_type   pair_sum_ff, pair_sum_in;
   logic [7:0]     px [4];

   logic           wide, tall, col_used, row_used, pair_done, first_of_pair;
   logic [DWW-1:0] col_lim, col_ext;
   logic [DWH-1:0] row_lim, row_ext;
   logic           col_wrap, row_wrap, last_here;
   logic           accept, emit, line_write, line_read;
   logic [AW-1:0]  idx;

   logic           s1_valid_ff, s1_valid_in;
   quad_sum_type   s1_sum_ff;
   logic           s1_tall_ff, s1_last_ff;
   logic [1:0]     s1_sh_ff;
   logic           s1_free, out_free;

   logic [QUAD_SUM_WIDTH-1:0] line_rd;
   quad_sum_type              line_q;
   logic [9:0]                tot [4];
   logic [7:0]                avg [4];
   logic                      rsp_valid_ff, rsp_valid_in;
   pixel_out_type             rsp_data_ff, rsp_data_in;

   // Configuration port.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign wr_value  = 32'(pwdata[CFG_DIM_WIDTH-1:0]);

   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      eff_w_in      = eff_w_ff;
      eff_h_in      = eff_h_ff;
      if (cfg_write) begin
         unique case (reg_index_type'(paddr[2]))
            REG_SRC_WIDTH: begin
               src_width_in = pwdata[CFG_DIM_WIDTH-1:0];
               if (wr_value == 0) eff_w_in = DWW'(1);
               else if (wr_value > 32'(MAX_WIDTH)) eff_w_in = DWW'(MAX_WIDTH);
               else eff_w_in = DWW'(wr_value);
            end
            REG_SRC_HEIGHT: begin
               src_height_in = pwdata[CFG_DIM_WIDTH-1:0];
               if (wr_value == 0) eff_h_in = DWH'(1);
               else if (wr_value > 32'(MAX_HEIGHT)) eff_h_in = DWH'(MAX_HEIGHT);
               else eff_h_in = DWH'(wr_value);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[2]))
         REG_SRC_WIDTH:  prdata = CSR_DATA_WIDTH'(src_width_ff);
         REG_SRC_HEIGHT: prdata = CSR_DATA_WIDTH'(src_height_ff);
         default:        prdata = '0;
      endcase
   end

   // Position decode for the incoming pixel.
   assign wide    = eff_w_ff > DWW'(1);
   assign tall    = eff_h_ff > DWH'(1);
   assign col_lim = wide ? {eff_w_ff[DWW-1:1], 1'b0} : DWW'(1);
   assign row_lim = tall ? {eff_h_ff[DWH-1:1], 1'b0} : DWH'(1);
   assign col_ext = DWW'(col_ff);
   assign row_ext = DWH'(row_ff);

   assign col_used      = col_ext < col_lim;
   assign row_used      = row_ext < row_lim;
   assign first_of_pair = !wide || !col_ff[0];
   assign pair_done     = !wide || col_ff[0];
   assign col_wrap      = col_ext == eff_w_ff - DWW'(1);
   assign row_wrap      = row_ext == eff_h_ff - DWH'(1);
   assign last_here     = (col_ext == col_lim - DWW'(1)) && (row_ext == row_lim - DWH'(1));

   assign accept     = req_valid && req_ready;
   assign line_write = accept && col_used && row_used && pair_done && tall && !row_ff[0];
   assign emit       = col_used && row_used && pair_done && !(tall && !row_ff[0]);
   assign line_read  = accept && emit && tall;

   assign idx = (wide && (32'(col_ff >> 1) < 32'(LINE_DEPTH))) ? AW'(col_ff >> 1) : '0;

   assign px[0] = req_data.in_ch0;
   assign px[1] = req_data.in_ch1;
   assign px[2] = req_data.in_ch2;
   assign px[3] = req_data.in_ch3;

   always_comb begin
      pair_sum_in = pair_sum_ff;
      if (accept && col_used && row_used) begin
         for (int k = 0; k < 4; k++) begin
            pair_sum_in[k] = first_of_pair ? {1'b0, px[k]} : pair_sum_ff[k] + {1'b0, px[k]};
         end
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   bds_line_ram #(
      .WIDTH      (QUAD_SUM_WIDTH),
      .DEPTH      (LINE_DEPTH),
      .ADDR_WIDTH (AW)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_write),
      .wr_addr (idx),
      .wr_data (pair_sum_in),
      .rd_en   (line_read),
      .rd_addr (idx),
      .rd_data (line_rd)
   );

   // Pipeline flow: the result register frees the sum stage, which frees the input.
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign s1_free     = !s1_valid_ff || out_free;
   assign req_ready   = s1_free;
   assign s1_valid_in = s1_free ? (accept && emit) : s1_valid_ff;

   assign line_q = quad_sum_type'(line_rd);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         tot[k] = {1'b0, s1_sum_ff[k]} + (s1_tall_ff ? {1'b0, line_q[k]} : 10'd0);
         avg[k] = 8'(tot[k] >> s1_sh_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_data_in.out_ch0    = avg[0];
            rsp_data_in.out_ch1    = avg[1];
            rsp_data_in.out_ch2    = avg[2];
            rsp_data_in.out_ch3    = avg[3];
            rsp_data_in.last_pixel = s1_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= CFG_DIM_WIDTH'(1);
         src_height_ff <= CFG_DIM_WIDTH'(1);
         eff_w_ff      <= DWW'(1);
         eff_h_ff      <= DWH'(1);
         col_ff        <= '0;
         row_ff        <= '0;
         pair_sum_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         eff_w_ff      <= eff_w_in;
         eff_h_ff      <= eff_h_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         pair_sum_ff   <= pair_sum_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && accept) begin
         s1_sum_ff  <= pair_sum_in;
         s1_tall_ff <= tall;
         s1_sh_ff   <= {1'b0, wide} + {1'b0, tall};
         s1_last_ff <= last_here;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BDS_ASSERT_SAME(a_col_in_range, clock, reset, 1'b1, col_ext < eff_w_ff)
   `BDS_ASSERT_SAME(a_row_in_range, clock, reset, 1'b1, row_ext < eff_h_ff)
   `BDS_ASSERT_SAME(a_ram_one_access, clock, reset, line_write, !line_read)
   `BDS_ASSERT_NEXT(a_level_wraps, clock, reset,
      accept && !cfg_write && col_wrap && row_wrap, col_ff == '0 && row_ff == '0)
   `BDS_ASSERT_NEXT(a_stall_holds, clock, reset,
      s1_valid_ff && !out_free, s1_valid_ff && $stable(s1_sum_ff) && $stable(line_rd))

endmodule

/* verif/box_downsample_2x2_rgba8_test.sv */
// Self-checking testbench for the 2x2 RGBA8 box downsampler (box_downsample_2x2_rgba8).
// It drives source pixels and APB register writes, predicts every averaged pixel and
// checks each rsp transfer against that prediction. It depends on bds_pkg and the RTL.
module box_downsample_2x2_rgba8_test
   import bds_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LEVEL_MAX_W = DEFAULT_MAX_WIDTH;
   localparam int unsigned LEVEL_MAX_H = DEFAULT_MAX_HEIGHT;
   localparam int unsigned LINE_DEPTH = LEVEL_MAX_W / 2;
   localparam int unsigned REG_STRIDE = 4;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned RANDOM_PIXELS = 1200;
   localparam int unsigned SATURATED_PIXELS = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pixel_in_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pixel_out_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   logic [CFG_DIM_WIDTH-1:0] width_reg;
   logic [CFG_DIM_WIDTH-1:0] height_reg;
   int unsigned col_pos;
   int unsigned row_pos;
   quad_sum_type run_pair;
   quad_sum_type line_store [LINE_DEPTH];

   pixel_out_type avg_expected [$];
   int unsigned mismatch_count = 0;
   int unsigned pixels_sent = 0;
   int unsigned stall_left = 0;
   bit no_idle = 1'b0;

   box_downsample_2x2_rgba8 u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #10 clock = ~clock;

   function automatic int unsigned clamp_dim(input logic [CFG_DIM_WIDTH-1:0] v,
                                             input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return 32'(v);
   endfunction

   function automatic int unsigned idle_len();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         if (mismatch_count < 10)
            $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Advances the position counters and returns the averaged pixel when a block completes.
   function automatic void mip_step(input pixel_in_type px, output bit emitted,
                                    output pixel_out_type avg);
      int unsigned w, h, ow, oh, idx, tot, sh;
      bit wide, tall, col_used, row_used, first_px, pair_done;
      logic [7:0] chan_in [4];
      logic [7:0] chan_out [4];
      chan_in[0] = px.in_ch0;
      chan_in[1] = px.in_ch1;
      chan_in[2] = px.in_ch2;
      chan_in[3] = px.in_ch3;
      w = clamp_dim(width_reg, LEVEL_MAX_W);
      h = clamp_dim(height_reg, LEVEL_MAX_H);
      wide = w > 1;
      tall = h > 1;
      ow = wide ? w / 2 : 1;
      oh = tall ? h / 2 : 1;
      col_used = wide ? (col_pos < 2 * ow) : (col_pos == 0);
      row_used = tall ? (row_pos < 2 * oh) : (row_pos == 0);
      emitted = 1'b0;
      avg = '0;
      if (col_used && row_used) begin
         first_px = !wide || (col_pos % 2 == 0);
         pair_done = !wide || (col_pos % 2 == 1);
         for (int k = 0; k < 4; k++)
            run_pair[k] = first_px ? {1'b0, chan_in[k]} : run_pair[k] + {1'b0, chan_in[k]};
         if (pair_done) begin
            idx = wide ? col_pos / 2 : 0;
            if (idx >= LINE_DEPTH) idx = 0;
            if (tall && row_pos % 2 == 0) begin
               line_store[idx] = run_pair;
            end else begin
               sh = int'(wide) + int'(tall);
               for (int k = 0; k < 4; k++) begin
                  tot = 32'(run_pair[k]);
                  if (tall) tot += 32'(line_store[idx][k]);
                  chan_out[k] = 8'(tot >> sh);
               end
               avg.out_ch0 = chan_out[0];
               avg.out_ch1 = chan_out[1];
               avg.out_ch2 = chan_out[2];
               avg.out_ch3 = chan_out[3];
               avg.last_pixel = ((wide ? col_pos / 2 : 0) == ow - 1) &&
                                ((tall ? row_pos / 2 : 0) == oh - 1);
               emitted = 1'b1;
            end
         end
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready = 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
   end

   always @(posedge clock) begin
      pixel_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (avg_expected.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: unexpected output pixel %h", $realtime, rsp_data);
            mismatch_count++;
         end else begin
            want = avg_expected.pop_front();
            check_field("out_ch0", 32'(want.out_ch0), 32'(rsp_data.out_ch0));
            check_field("out_ch1", 32'(want.out_ch1), 32'(rsp_data.out_ch1));
            check_field("out_ch2", 32'(want.out_ch2), 32'(rsp_data.out_ch2));
            check_field("out_ch3", 32'(want.out_ch3), 32'(rsp_data.out_ch3));
            check_field("last_pixel", 32'(want.last_pixel), 32'(rsp_data.last_pixel));
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_pixel(input pixel_in_type px);
      int unsigned gap;
      bit emitted;
      pixel_out_type avg;
      gap = idle_len();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = px;
      do @(posedge clock); while (!req_ready);
      mip_step(px, emitted, avg);
      if (emitted) avg_expected.push_back(avg);
      pixels_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] random_byte();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hff;
      return 8'($urandom);
   endfunction

   task automatic send_random_pixels(input int unsigned count);
      pixel_in_type px;
      repeat (count) begin
         px.in_ch0 = random_byte();
         px.in_ch1 = random_byte();
         px.in_ch2 = random_byte();
         px.in_ch3 = random_byte();
         send_pixel(px);
      end
   endtask

   task automatic settle_block();
      req_valid = 1'b0;
      while (avg_expected.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input reg_index_type index, input logic [CFG_DIM_WIDTH-1:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = CSR_ADDR_WIDTH'(int'(index) * REG_STRIDE);
      pwdata = CSR_DATA_WIDTH'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (index == REG_SRC_WIDTH) width_reg = value;
      else height_reg = value;
      col_pos = 0;
      row_pos = 0;
      @(negedge clock);
      penable = 1'b0;
      pwrite = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      check_field("register readback", 32'(value), prdata);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic set_size(input logic [CFG_DIM_WIDTH-1:0] w, input logic [CFG_DIM_WIDTH-1:0] h);
      settle_block();
      csr_write(REG_SRC_WIDTH, w);
      csr_write(REG_SRC_HEIGHT, h);
   endtask

   task automatic test_default_size();
      send_pixel('0);
      send_pixel('1);
      send_random_pixels(2);
   endtask

   task automatic test_full_scale_blocks();
      set_size(2, 2);
      repeat (4) send_pixel('1);
      send_pixel('1);
      send_pixel('0);
      send_pixel('0);
      send_pixel('0);
      send_pixel({8'hff, 8'h00, 8'hff, 8'h01});
      send_pixel({8'h00, 8'hff, 8'hff, 8'h01});
      send_pixel({8'hff, 8'hff, 8'h00, 8'h01});
      send_pixel({8'hff, 8'hff, 8'hff, 8'h00});
   endtask

   task automatic test_odd_trailing();
      set_size(3, 3);
      send_random_pixels(9);
   endtask

   task automatic test_single_axis();
      set_size(1, 2);
      send_random_pixels(2);
      set_size(2, 1);
      send_random_pixels(2);
      set_size(0, 0);
      send_random_pixels(1);
   endtask

   task automatic test_restart();
      set_size(4, 2);
      send_random_pixels(5);
      set_size(4, 2);
      send_random_pixels(8);
   endtask

   task automatic test_saturated_size();
      set_size(8191, 1);
      send_random_pixels(SATURATED_PIXELS);
      set_size(5, 8191);
      send_random_pixels(15);
   endtask

   function automatic logic [CFG_DIM_WIDTH-1:0] pick_dim();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 6) return '0;
      if (r < 16) return CFG_DIM_WIDTH'(1);
      if (r < 80) return CFG_DIM_WIDTH'($urandom_range(2, 8));
      return CFG_DIM_WIDTH'($urandom_range(9, 24));
   endfunction

   task automatic test_random_levels();
      int unsigned start, total, reps;
      start = pixels_sent;
      while (pixels_sent - start < RANDOM_PIXELS) begin
         set_size(pick_dim(), pick_dim());
         no_idle = ($urandom_range(0, 4) == 0);
         total = clamp_dim(width_reg, LEVEL_MAX_W) * clamp_dim(height_reg, LEVEL_MAX_H);
         reps = $urandom_range(1, 3);
         for (int r = 0; r < reps; r++) begin
            if (r == reps - 1 && $urandom_range(0, 5) == 0)
               send_random_pixels($urandom_range(1, total));
            else
               send_random_pixels(total);
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      width_reg = 1;
      height_reg = 1;
      col_pos = 0;
      row_pos = 0;
      run_pair = '0;
      foreach (line_store[i]) line_store[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_default_size();
      test_full_scale_blocks();
      test_odd_trailing();
      test_single_axis();
      test_restart();
      test_saturated_size();
      test_random_levels();
      settle_block();
      mismatch_count += avg_expected.size();
      if (mismatch_count == 0)
         $display("box_downsample_2x2_rgba8: match");
      else
         $display("box_downsample_2x2_rgba8: mismatch");
      $finish;
   end

   initial begin
      #50ms;
      $display("box_downsample_2x2_rgba8: mismatch");
      $finish;
   end

endmodule
